### rtl/ipd_pkg.sv
// Shared types, codes and constants of the illuminance PID dimmer.
package ipd_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 20;
  localparam int LUX_W          = 17;
  localparam int TIME_W         = 32;
  localparam int SET_W          = 32;
  localparam int LEVEL_W        = 8;
  localparam int ERR_W          = LUX_W + 1;
  localparam int DERIV_W        = ERR_W + 1;
  localparam int SUM_W          = 32;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 20'd6554;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET = 20'd655;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 20'd655;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 8'sd100;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -8'sd1;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [SET_W-1:0] set_level;
    logic [LUX_W-1:0]        target_lux;
    logic [LUX_W-1:0]        measured_lux;
    logic [TIME_W-1:0]       sample_time_s;
    logic [TIME_W-1:0]       now_s;
  } item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      loop_active;
    logic signed [SUM_W-1:0]   error_sum;
    logic signed [ERR_W-1:0]   previous_error;
    logic [TIME_W-1:0]         last_control_time;
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] light_level;
    logic                      led_on;
    logic                      sample_applied;
  } result_t;

endpackage

### rtl/ipd_cfg.sv
// Gain register file written through the configuration channel.
module ipd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [ipd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ipd_pkg::GAIN_W-1:0]          cfg_data,
  output logic                                cfg_ready,
  output ipd_pkg::gains_t                     gains
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.p <= ipd_pkg::GAIN_P_RESET;
      gains.i <= ipd_pkg::GAIN_I_RESET;
      gains.d <= ipd_pkg::GAIN_D_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipd_pkg::REG_GAIN_P: gains.p <= cfg_data;
        ipd_pkg::REG_GAIN_I: gains.i <= cfg_data;
        ipd_pkg::REG_GAIN_D: gains.d <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ipd_step.sv
// Combinational update of the regulator state and result for one item.
module ipd_step (
  input  ipd_pkg::item_t   item,
  input  ipd_pkg::state_t  state,
  input  ipd_pkg::gains_t  gains,
  output ipd_pkg::state_t  state_next,
  output ipd_pkg::result_t result
);

  localparam int F      = ipd_pkg::GAIN_FRAC_BITS;
  localparam int LW     = ipd_pkg::LEVEL_W;
  localparam int EW     = ipd_pkg::ERR_W;
  localparam int DW     = ipd_pkg::DERIV_W;
  localparam int SW     = ipd_pkg::SUM_W;
  localparam int GW     = ipd_pkg::GAIN_W;
  localparam int PP_W   = GW + 1 + EW;
  localparam int PI_W   = GW + 1 + SW;
  localparam int PD_W   = GW + 1 + DW;
  localparam int NUM_W  = PI_W + 2;
  localparam int Q_W    = NUM_W - F;

  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [EW-1:0]    err;
  logic signed [DW-1:0]    deriv;
  logic signed [SW-1:0]    sum_base;
  logic signed [SW:0]      acc;
  logic signed [SW-1:0]    acc_sat;
  logic signed [SW-1:0]    sum_new;
  logic signed [PP_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [NUM_W-1:0] level_term;
  logic signed [NUM_W-1:0] num;
  logic signed [Q_W-1:0]   quot;
  logic signed [LW-1:0]    pid_level;
  logic signed [LW-1:0]    set_clamped;
  logic                    fresh;
  logic                    applied;

  always_comb begin
    err = $signed({1'b0, item.target_lux}) - $signed({1'b0, item.measured_lux});
    // The derivative is zero on the first sample after the loop is (re)activated.
    deriv = state.loop_active
          ? ($signed({state.previous_error[EW-1], state.previous_error})
             - $signed({err[EW-1], err}))
          : '0;
    sum_base = state.loop_active ? state.error_sum : '0;
    acc = $signed({sum_base[SW-1], sum_base}) + $signed({{(SW+1-EW){err[EW-1]}}, err});
    if (acc[SW] != acc[SW-1]) begin
      acc_sat = acc[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc[SW-1:0];
    end
    // The integral restarts whenever the error changes sign.
    sum_new = (state.previous_error[EW-1] == err[EW-1]) ? acc_sat : '0;

    prod_p = $signed({1'b0, gains.p}) * err;
    prod_i = $signed({1'b0, gains.i}) * sum_new;
    prod_d = $signed({1'b0, gains.d}) * deriv;
    level_term = {{(NUM_W-LW-F){state.level[LW-1]}}, state.level, {F{1'b0}}};
    num = level_term + NUM_W'(prod_p) + NUM_W'(prod_i) + NUM_W'(prod_d);

    // Arithmetic shift rounds down; bump negative values with a remainder
    // so the quotient truncates toward zero.
    quot = num[NUM_W-1:F];
    if (num[NUM_W-1] && (|num[F-1:0])) begin
      quot = quot + Q_W'(1);
    end
    if (quot > Q_W'(ipd_pkg::LEVEL_MAX)) begin
      pid_level = ipd_pkg::LEVEL_MAX;
    end else if (quot < Q_W'(ipd_pkg::LEVEL_MIN)) begin
      pid_level = ipd_pkg::LEVEL_MIN;
    end else begin
      pid_level = quot[LW-1:0];
    end

    if (item.set_level > ipd_pkg::SET_W'(ipd_pkg::LEVEL_MAX)) begin
      set_clamped = ipd_pkg::LEVEL_MAX;
    end else if (item.set_level < ipd_pkg::SET_W'(ipd_pkg::LEVEL_MIN)) begin
      set_clamped = ipd_pkg::LEVEL_MIN;
    end else begin
      set_clamped = item.set_level[LW-1:0];
    end

    fresh   = item.sample_time_s > state.last_control_time;
    applied = 1'b0;
    state_next = state;
    unique case (item.operation)
      ipd_pkg::OP_SET: begin
        state_next.level             = set_clamped;
        state_next.last_control_time = item.now_s;
        state_next.loop_active       = 1'b0;
      end
      ipd_pkg::OP_SAMPLE: begin
        if (fresh) begin
          applied                      = 1'b1;
          state_next.level             = pid_level;
          state_next.loop_active       = 1'b1;
          state_next.error_sum         = sum_new;
          state_next.previous_error    = err;
          state_next.last_control_time = item.now_s;
        end
      end
      default: ;
    endcase

    result.light_level    = state_next.level;
    result.led_on         = state_next.level > $signed(LW'(0));
    result.sample_applied = applied;
  end

endmodule

### rtl/illuminance_pid_dimmer_core.sv
// Illuminance PID dimmer: input register, single-pass update, result register.
//
// Input channel: in_valid/in_stall carry one operation per beat (read level,
// direct set, or lux sample with its timestamps). A beat moves when in_valid
// is high and in_stall is low.
// Output channel: out_valid/out_stall deliver exactly one result beat per
// input beat, in order: light level, LED flag and whether a sample was used.
// Configuration channel: cfg_valid/cfg_ready write the P, I and D gains
// (index 0, 1, 2; unsigned Q16, 20 bits). cfg_ready is always high; write
// only while no beats are in flight.
// A taken beat waits in the input register; its result then goes to the result
// register. Throughput: one beat per cycle unless the receiver stalls; the state
// update and all three gain multiplies sit between the two registers.
// Reset (rst, synchronous): level -1, loop inactive, integral, previous
// error and last control time zero, gains at their defaults, both
// registers empty.
// When the receiver stalls, the result is held and the input register keeps
// its beat; in_stall rises once both are full.
module illuminance_pid_dimmer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            operation,
  input  logic signed [ipd_pkg::SET_W-1:0]      set_level,
  input  logic [ipd_pkg::LUX_W-1:0]             target_lux,
  input  logic [ipd_pkg::LUX_W-1:0]             measured_lux,
  input  logic [ipd_pkg::TIME_W-1:0]            sample_time_s,
  input  logic [ipd_pkg::TIME_W-1:0]            now_s,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ipd_pkg::LEVEL_W-1:0]    light_level,
  output logic                                  led_on,
  output logic                                  sample_applied,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ipd_pkg::GAIN_W-1:0]            cfg_data
);

  ipd_pkg::gains_t  gains;
  ipd_pkg::item_t   item;
  logic             item_valid;
  ipd_pkg::state_t  state;
  ipd_pkg::state_t  state_next;
  ipd_pkg::result_t step_result;
  ipd_pkg::result_t result;
  logic             advance;

  ipd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .gains     (gains)
  );

  ipd_step u_step (
    .item       (item),
    .state      (state),
    .gains      (gains),
    .state_next (state_next),
    .result     (step_result)
  );

  // The held item moves on when the result register is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid                 <= 1'b0;
      out_valid                  <= 1'b0;
      state.level                <= ipd_pkg::LEVEL_MIN;
      state.loop_active          <= 1'b0;
      state.error_sum            <= '0;
      state.previous_error       <= '0;
      state.last_control_time    <= '0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
        if (item_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.operation     <= operation;
      item.set_level     <= set_level;
      item.target_lux    <= target_lux;
      item.measured_lux  <= measured_lux;
      item.sample_time_s <= sample_time_s;
      item.now_s         <= now_s;
    end
    if (advance && item_valid) begin
      result <= step_result;
    end
  end

  assign light_level    = result.light_level;
  assign led_on         = result.led_on;
  assign sample_applied = result.sample_applied;

endmodule

### bench/ipd_checker.sv
// Checker for the PID dimmer: watches all three channels, predicts each result and compares.
`timescale 1ns / 1ps
module ipd_checker
  import ipd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic signed [SET_W-1:0]     set_level,
  input  logic [LUX_W-1:0]            target_lux,
  input  logic [LUX_W-1:0]            measured_lux,
  input  logic [TIME_W-1:0]           sample_time_s,
  input  logic [TIME_W-1:0]           now_s,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [LEVEL_W-1:0]   light_level,
  input  logic                        led_on,
  input  logic                        sample_applied,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [GAIN_W-1:0]           cfg_data,
  output int                          fail_count,
  output int                          outstanding
);

  localparam longint UNITY  = longint'(1) << GAIN_FRAC_BITS;
  localparam longint SUM_HI = 2147483647;
  localparam longint SUM_LO = -SUM_HI - 1;

  gains_t                    gains;
  logic signed [LEVEL_W-1:0] level;
  logic                      loop_on;
  logic signed [SUM_W-1:0]   integral;
  logic signed [ERR_W-1:0]   last_err;
  logic [TIME_W-1:0]         ctrl_time;
  result_t                   levels_due[$];
  int                        errors = 0;

  function automatic logic signed [LEVEL_W-1:0] clamp_level(input longint v);
    if (v > LEVEL_MAX) return LEVEL_MAX;
    if (v < LEVEL_MIN) return LEVEL_MIN;
    return LEVEL_W'(v);
  endfunction

  // One regulator step: updates the predicted state and returns the result it reports.
  task automatic regulate(input item_t it, output result_t res);
    longint err;
    longint slope;
    longint acc;
    longint num;
    logic   used;
    used = 1'b0;
    case (it.operation)
      OP_SET: begin
        level     = clamp_level(longint'(it.set_level));
        ctrl_time = it.now_s;
        loop_on   = 1'b0;
      end
      OP_SAMPLE: begin
        if (it.sample_time_s > ctrl_time) begin
          err   = longint'(it.target_lux) - longint'(it.measured_lux);
          slope = 0;
          // The derivative only exists once the loop has a previous sample of its own.
          if (!loop_on) begin
            loop_on  = 1'b1;
            integral = '0;
          end else begin
            slope = longint'(last_err) - err;
          end
          if ((last_err < 0) == (err < 0)) begin
            acc = longint'(integral) + err;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            integral = SUM_W'(acc);
          end else begin
            integral = '0;
          end
          last_err = ERR_W'(err);
          num = longint'(level) * UNITY
              + longint'(gains.p) * err
              + longint'(gains.i) * longint'(integral)
              + longint'(gains.d) * slope;
          level     = clamp_level(num / UNITY);
          ctrl_time = it.now_s;
          used      = 1'b1;
        end
      end
      default: ;
    endcase
    res.light_level    = level;
    res.led_on         = level > 0;
    res.sample_applied = used;
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      gains.p   = GAIN_P_RESET;
      gains.i   = GAIN_I_RESET;
      gains.d   = GAIN_D_RESET;
      level     = LEVEL_MIN;
      loop_on   = 1'b0;
      integral  = '0;
      last_err  = '0;
      ctrl_time = '0;
      levels_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.light_level    = light_level;
        got.led_on         = led_on;
        got.sample_applied = sample_applied;
        if (levels_due.size() == 0) begin
          $display("%0t: result beat with none expected, level %0d", $time, light_level);
          errors++;
        end else begin
          want = levels_due.pop_front();
          if (got.light_level !== want.light_level) begin
            $display("%0t: light_level expected %0d got %0d", $time,
                     want.light_level, got.light_level);
            errors++;
          end
          if (got.led_on !== want.led_on) begin
            $display("%0t: led_on expected %0b got %0b", $time, want.led_on, got.led_on);
            errors++;
          end
          if (got.sample_applied !== want.sample_applied) begin
            $display("%0t: sample_applied expected %0b got %0b", $time,
                     want.sample_applied, got.sample_applied);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P: gains.p = cfg_data;
          REG_GAIN_I: gains.i = cfg_data;
          REG_GAIN_D: gains.d = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        it.operation     = operation;
        it.set_level     = set_level;
        it.target_lux    = target_lux;
        it.measured_lux  = measured_lux;
        it.sample_time_s = sample_time_s;
        it.now_s         = now_s;
        regulate(it, want);
        levels_due.push_back(want);
      end
    end
    outstanding <= levels_due.size();
    fail_count  <= errors;
  end

endmodule

### bench/tb.sv
// Stimulus and verdict for the illuminance PID dimmer core.
`timescale 1ns / 1ps
module tb;
  import ipd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         LUX_MAX     = (1 << LUX_W) - 1;
  localparam int         GAIN_MAX    = (1 << GAIN_W) - 1;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 48;
  localparam int         SEGMENTS    = 8;
  localparam int         SEG_ITEMS   = 110;
  localparam int         WINDUP_RUN  = 40;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                operation;
  logic signed [SET_W-1:0]   set_level;
  logic [LUX_W-1:0]          target_lux;
  logic [LUX_W-1:0]          measured_lux;
  logic [TIME_W-1:0]         sample_time_s;
  logic [TIME_W-1:0]         now_s;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [LEVEL_W-1:0] light_level;
  logic                      led_on;
  logic                      sample_applied;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [GAIN_W-1:0]         cfg_data;
  int                        fail_count;
  int                        outstanding;

  int                        idle_pct;
  int                        stall_pct;
  bit                        hold_go;
  logic [TIME_W-1:0]         wall;
  logic [TIME_W-1:0]         prev_now;

  illuminance_pid_dimmer_core i_dut (
    .clk, .rst, .in_valid, .in_stall, .operation, .set_level, .target_lux,
    .measured_lux, .sample_time_s, .now_s, .out_valid, .out_stall, .light_level,
    .led_on, .sample_applied, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ipd_checker i_check (
    .clk, .rst, .in_valid, .in_stall, .operation, .set_level, .target_lux,
    .measured_lux, .sample_time_s, .now_s, .out_valid, .out_stall, .light_level,
    .led_on, .sample_applied, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic item_t beat(input logic [1:0] op, input logic [SET_W-1:0] lvl,
                                 input int tgt, input int meas,
                                 input logic [TIME_W-1:0] ts, input logic [TIME_W-1:0] now);
    item_t it;
    it.operation     = op;
    it.set_level     = lvl;
    it.target_lux    = LUX_W'(tgt);
    it.measured_lux  = LUX_W'(meas);
    it.sample_time_s = ts;
    it.now_s         = now;
    return it;
  endfunction

  task automatic offer(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= it.operation;
    set_level     <= it.set_level;
    target_lux    <= it.target_lux;
    measured_lux  <= it.measured_lux;
    sample_time_s <= it.sample_time_s;
    now_s         <= it.now_s;
    prev_now      = it.now_s;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every result in flight has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_gain(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                            input logic [GAIN_W-1:0] d);
    write_gain(REG_GAIN_P, p);
    write_gain(REG_GAIN_I, i);
    write_gain(REG_GAIN_D, d);
    cfg_valid <= 1'b0;
  endtask

  // Mostly fresh samples near the target so the loop keeps moving, with sets,
  // reads, stale samples and fully random beats mixed in.
  task automatic random_beat();
    int r;
    int tgt;
    int meas;
    r    = $urandom_range(99);
    wall = wall + $urandom_range(4, 1);
    if ($urandom_range(99) < 2) wall = $urandom();
    tgt = $urandom_range(LUX_MAX);
    if ($urandom_range(3) == 0) begin
      meas = $urandom_range(LUX_MAX);
    end else begin
      meas = tgt + int'($urandom_range(600)) - 300;
      if (meas < 0) meas = 0;
      if (meas > LUX_MAX) meas = LUX_MAX;
    end
    if (r < 8) begin
      offer(beat(OP_READ, $urandom(), tgt, meas, $urandom(), $urandom()));
    end else if (r < 18) begin
      if ($urandom_range(3) == 0)
        offer(beat(OP_SET, $urandom(), tgt, meas, $urandom(), wall));
      else
        offer(beat(OP_SET, int'($urandom_range(110)) - 5, tgt, meas, $urandom(), wall));
    end else if (r < 82) begin
      offer(beat(OP_SAMPLE, $urandom(), tgt, meas, wall, wall));
    end else if (r < 90) begin
      offer(beat(OP_SAMPLE, $urandom(), tgt, meas, prev_now - $urandom_range(5), wall));
    end else begin
      offer(beat(2'($urandom_range(3)), $urandom(), $urandom_range(LUX_MAX),
                 $urandom_range(LUX_MAX), $urandom(), $urandom()));
    end
  endtask

  initial begin
    int seg;
    int n;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_READ;
    set_level     = '0;
    target_lux    = '0;
    measured_lux  = '0;
    sample_time_s = '0;
    now_s         = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_GAIN_P;
    cfg_data      = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    prev_now      = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, still at the reset gains.
    offer(beat(OP_READ, 0, 0, 0, 0, 0));
    offer(beat(OP_UNUSED, 55, 300, 100, 40, 40));
    offer(beat(OP_SAMPLE, 0, 100, 0, 0, 5));
    offer(beat(OP_SAMPLE, 0, LUX_MAX, 0, 1, 1));
    offer(beat(OP_SAMPLE, 0, 7, 3, 1, 2));
    offer(beat(OP_SAMPLE, 0, 0, LUX_MAX, 2, 2));
    offer(beat(OP_SAMPLE, 0, 500, 500, 3, 3));
    offer(beat(OP_SET, 32'h7FFF_FFFF, 0, 0, 0, 4));
    offer(beat(OP_SET, 32'h8000_0000, 0, 0, 0, 5));
    offer(beat(OP_SET, 0, 0, 0, 0, 6));
    offer(beat(OP_SET, 50, 0, 0, 0, 7));
    offer(beat(OP_SAMPLE, 0, 1000, 900, 8, 8));
    offer(beat(OP_SAMPLE, 0, 1000, 1100, 9, 9));
    offer(beat(OP_SAMPLE, 0, 1000, 1050, 10, 10));
    offer(beat(OP_READ, 0, 0, 0, 0, 0));
    offer(beat(OP_SET, 101, 0, 0, 0, 11));
    offer(beat(OP_SET, -2, 0, 0, 0, 12));
    offer(beat(OP_SET, 100, 0, 0, 0, 13));
    offer(beat(OP_SAMPLE, 0, 0, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    offer(beat(OP_SAMPLE, 0, 20, 5, 32'hFFFF_FFFF, 0));
    offer(beat(OP_SET, 1, 0, 0, 0, 0));
    offer(beat(OP_SAMPLE, 0, 20, 5, 32'h8000_0000, 14));
    offer(beat(OP_UNUSED, $urandom(), LUX_MAX, LUX_MAX, $urandom(), $urandom()));
    drain();

    // Hold the error at full scale in one direction so the integral builds up,
    // then flip it so the integral restarts and builds up the other way.
    wall = 100;
    for (n = 0; n < WINDUP_RUN; n++) begin
      wall = wall + 1;
      offer(beat(OP_SAMPLE, 0, LUX_MAX, 0, wall, wall));
    end
    for (n = 0; n < WINDUP_RUN; n++) begin
      wall = wall + 1;
      offer(beat(OP_SAMPLE, 0, 0, LUX_MAX, wall, wall));
    end
    drain();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 75; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      case (seg)
        0:       load_gains(GAIN_W'(GAIN_MAX), GAIN_W'(GAIN_MAX), GAIN_W'(GAIN_MAX));
        1:       load_gains(0, 0, 0);
        2:       load_gains(65536, 6554, 32768);
        4:       load_gains(GAIN_W'(GAIN_MAX), 0, GAIN_W'(GAIN_MAX));
        5:       load_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
        6:       load_gains(0, GAIN_W'(GAIN_MAX), 0);
        default: load_gains(GAIN_W'($urandom_range(GAIN_MAX)),
                            GAIN_W'($urandom_range(GAIN_MAX)),
                            GAIN_W'($urandom_range(GAIN_MAX)));
      endcase
      // With no sender gaps, a long receiver hold-off backs the core up into its input.
      if (seg % 4 == 0) hold_go = 1'b1;
      for (n = 0; n < SEG_ITEMS; n++) random_beat();
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
